@@ hw/rtl/bmp24_pkg.sv @@
package bmp24_pkg;

   // parser phases
   typedef enum logic [1:0] {
      PH_HEADER = 2'd0,
      PH_PIXEL  = 2'd1,
      PH_PAD    = 2'd2,
      PH_IDLE   = 2'd3
   } phase_type;

   // result kinds carried on tuser
   localparam logic [1:0] ST_PIXEL     = 2'd0;
   localparam logic [1:0] ST_BAD_SIG   = 2'd1;
   localparam logic [1:0] ST_BAD_HDR   = 2'd2;
   localparam logic [1:0] ST_TOO_LARGE = 2'd3;

   localparam logic [15:0] SIG_BM       = 16'd19778;
   localparam logic [15:0] DEPTH_24     = 16'd24;
   localparam logic [31:0] HDR_LEN      = 32'd54;
   localparam logic [31:0] INFO_LEN     = 32'd40;
   localparam logic [5:0]  SIG_LAST_POS = 6'd1;
   localparam logic [5:0]  HDR_LAST_POS = 6'd53;
   localparam int          OUT_COORD_W  = 16;

   // header verdict for the byte being processed
   typedef struct packed {
      logic sig_bad;
      logic at_end;
      logic invalid;
      logic too_large;
   } hdr_status_type;

endpackage

@@ hw/rtl/bmp24_stream_parser.sv @@
// an accepted input beat passes the input register, then the result register, to its result on rsp_tvalid
// throughput: one byte per cycle while the result is not stalled, one input register and one result register
// a stalled result also holds the byte in the input register; a new byte is then taken only if that register is empty
// reset: synchronous, active high; the parser starts in the header phase and
// treats the next byte as byte 0 of a file
module bmp24_stream_parser
   import bmp24_pkg::*;
#(
   parameter int COORD_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tuser,   // [0] file_start
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // red, green, blue, pixel_row, pixel_column
   output logic [1:0]  rsp_tuser,   // [1:0] status
   output logic        rsp_tlast    // last_pixel
);

   // input register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_start_ff;
   logic       consume;

   // parse state
   phase_type             phase_ff, phase_in, phase_cur;
   logic [COORD_BITS-1:0] row_ff, row_in;
   logic [COORD_BITS-1:0] col_ff, col_in;
   logic [1:0]            comp_ff, comp_in;
   logic [7:0]            blue_ff, blue_in;
   logic [7:0]            green_ff, green_in;
   logic [1:0]            pad_ff, pad_in, pad_dec;

   // result register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [55:0] rsp_data_ff, rsp_data_in;
   logic [1:0]  rsp_user_ff, rsp_user_in;
   logic        rsp_last_ff, rsp_last_in;

   hdr_status_type hdr_status;
   logic [31:0]    image_width, image_height;
   logic [31:0]    width_m1, height_m1;
   logic [COORD_BITS+31:0] col_wide, row_wide;
   logic [COORD_BITS+OUT_COORD_W-1:0] col_out_wide, row_out_wide;
   logic hdr_step, is_last, row_end, emit;

   assign consume    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || consume;
   assign in_valid_in = (req_tvalid && req_tready) ? 1'b1 : (consume ? 1'b0 : in_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (req_tvalid && req_tready) begin
         in_byte_ff  <= req_tdata;
         in_start_ff <= req_tuser;
      end
   end

   assign phase_cur = in_start_ff ? PH_HEADER : phase_ff;
   assign hdr_step  = consume && (phase_cur == PH_HEADER);

   bmp24_hdr #(
      .COORD_BITS(COORD_BITS)
   ) u_hdr (
      .clock       (clock),
      .reset       (reset),
      .step        (hdr_step),
      .start       (in_start_ff),
      .data_byte   (in_byte_ff),
      .status      (hdr_status),
      .image_width (image_width),
      .image_height(image_height)
   );

   assign width_m1  = image_width - 32'd1;
   assign height_m1 = image_height - 32'd1;
   assign col_wide  = {32'd0, col_ff};
   assign row_wide  = {32'd0, row_ff};
   assign is_last   = (row_wide[31:0] == height_m1) && (col_wide[31:0] == width_m1);
   assign row_end   = (col_wide[31:0] == width_m1);
   assign pad_dec   = pad_ff - 2'd1;

   // next phase
   always_comb begin
      phase_in = phase_cur;
      case (phase_cur)
         PH_HEADER: begin
            if (hdr_status.sig_bad) begin
               phase_in = PH_IDLE;
            end else if (hdr_status.at_end) begin
               if (hdr_status.invalid || hdr_status.too_large) begin
                  phase_in = PH_IDLE;
               end else begin
                  phase_in = PH_PIXEL;
               end
            end
         end
         PH_PIXEL: begin
            if (comp_ff == 2'd2) begin
               if (is_last) begin
                  phase_in = PH_IDLE;
               end else if (row_end && (image_width[1:0] != 2'd0)) begin
                  phase_in = PH_PAD;
               end
            end
         end
         PH_PAD: begin
            if (pad_dec == 2'd0) begin
               phase_in = PH_PIXEL;
            end
         end
         default: phase_in = PH_IDLE;
      endcase
      if (!consume) begin
         phase_in = phase_ff;
      end
   end

   // counters and result
   always_comb begin
      row_in      = row_ff;
      col_in      = col_ff;
      comp_in     = comp_ff;
      blue_in     = blue_ff;
      green_in    = green_ff;
      pad_in      = pad_ff;
      emit        = 1'b0;
      rsp_user_in = ST_PIXEL;
      rsp_last_in = 1'b0;
      rsp_data_in = '0;
      case (phase_cur)
         PH_HEADER: begin
            if (hdr_status.sig_bad) begin
               emit        = 1'b1;
               rsp_user_in = ST_BAD_SIG;
            end else if (hdr_status.at_end) begin
               if (hdr_status.invalid) begin
                  emit        = 1'b1;
                  rsp_user_in = ST_BAD_HDR;
               end else if (hdr_status.too_large) begin
                  emit        = 1'b1;
                  rsp_user_in = ST_TOO_LARGE;
               end else begin
                  row_in  = '0;
                  col_in  = '0;
                  comp_in = 2'd0;
               end
            end
         end
         PH_PIXEL: begin
            case (comp_ff)
               2'd0: begin
                  blue_in = in_byte_ff;
                  comp_in = 2'd1;
               end
               2'd1: begin
                  green_in = in_byte_ff;
                  comp_in  = 2'd2;
               end
               default: begin
                  comp_in     = 2'd0;
                  emit        = 1'b1;
                  rsp_user_in = ST_PIXEL;
                  rsp_last_in = is_last;
                  rsp_data_in = {col_out_wide[OUT_COORD_W-1:0],
                                 row_out_wide[OUT_COORD_W-1:0],
                                 blue_ff, green_ff, in_byte_ff};
                  if (!is_last) begin
                     if (row_end) begin
                        col_in = '0;
                        row_in = row_ff + COORD_BITS'(1);
                        pad_in = image_width[1:0];
                     end else begin
                        col_in = col_ff + COORD_BITS'(1);
                     end
                  end
               end
            endcase
         end
         PH_PAD: begin
            pad_in = pad_dec;
         end
         default: ;
      endcase
   end

   assign col_out_wide = {{OUT_COORD_W{1'b0}}, col_ff};
   assign row_out_wide = {{OUT_COORD_W{1'b0}}, row_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HEADER;
         row_ff   <= '0;
         col_ff   <= '0;
         comp_ff  <= 2'd0;
         pad_ff   <= 2'd0;
      end else begin
         phase_ff <= phase_in;
         if (consume) begin
            row_ff  <= row_in;
            col_ff  <= col_in;
            comp_ff <= comp_in;
            pad_ff  <= pad_in;
         end
      end
      if (consume) begin
         blue_ff  <= blue_in;
         green_ff <= green_in;
      end
   end

   // result register: a beat is loaded when one is produced, cleared when taken
   assign rsp_valid_in = (consume && emit) ? 1'b1 :
                         (rsp_tready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (consume && emit) begin
         rsp_data_ff <= rsp_data_in;
         rsp_user_ff <= rsp_user_in;
         rsp_last_ff <= rsp_last_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

   // error beats carry an empty payload and never close an image
   a_err_payload : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser != ST_PIXEL)) |-> ((rsp_tdata == '0) && !rsp_tlast))
      else $error("error beat with payload");

   // the final pixel leaves the parser idle
   a_last_idle : assert property (@(posedge clock) disable iff (reset)
      (consume && emit && rsp_last_in) |=> (phase_ff == PH_IDLE))
      else $error("parser not idle after final pixel");

   // padding phase always has bytes left to skip
   a_pad_nonzero : assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_PAD) |-> (pad_ff != 2'd0))
      else $error("padding phase with no bytes left");

   // column stays within the row while pixels are gathered
   a_col_range : assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_PIXEL) |-> (col_wide[31:0] <= width_m1))
      else $error("column beyond image width");

endmodule

@@ hw/rtl/bmp24_hdr.sv @@
module bmp24_hdr
   import bmp24_pkg::*;
#(
   parameter int COORD_BITS = 16
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           step,
   input  logic           start,
   input  logic [7:0]     data_byte,
   output hdr_status_type status,
   output logic [31:0]    image_width,
   output logic [31:0]    image_height
);

   localparam logic [32:0] COORD_LIMIT = 33'd1 << COORD_BITS;

   logic [5:0]  pos_ff, pos_in, pos_cur;
   logic [15:0] sig_ff, sig_in, sig_cur;
   logic [31:0] fsize_ff, fsize_in;
   logic [31:0] offset_ff, offset_in;
   logic [31:0] info_ff, info_in;
   logic [31:0] width_ff, width_in;
   logic [31:0] height_ff, height_in;
   logic [15:0] planes_ff, planes_in;
   logic [15:0] bpp_ff, bpp_in;
   logic [31:0] compr_ff, compr_in;
   logic [31:0] isize_ff, isize_in;

   // a start beat sees position and signature as cleared; the other fields clear as it is taken
   assign pos_cur = start ? 6'd0 : pos_ff;
   assign sig_cur = start ? 16'd0 : sig_ff;

   always_comb begin
      pos_in    = pos_ff;
      sig_in    = sig_ff;
      fsize_in  = fsize_ff;
      offset_in = offset_ff;
      info_in   = info_ff;
      width_in  = width_ff;
      height_in = height_ff;
      planes_in = planes_ff;
      bpp_in    = bpp_ff;
      compr_in  = compr_ff;
      isize_in  = isize_ff;
      if (step) begin
         if (start) begin
            fsize_in  = '0;
            offset_in = '0;
            info_in   = '0;
            width_in  = '0;
            height_in = '0;
            planes_in = '0;
            bpp_in    = '0;
            compr_in  = '0;
            isize_in  = '0;
         end
         sig_in = sig_cur;
         // little-endian fields shift in from the top
         case (pos_cur) inside
            [6'd0:6'd1]:   sig_in    = {data_byte, sig_cur[15:8]};
            [6'd2:6'd5]:   fsize_in  = {data_byte, fsize_ff[31:8]};
            [6'd10:6'd13]: offset_in = {data_byte, offset_ff[31:8]};
            [6'd14:6'd17]: info_in   = {data_byte, info_ff[31:8]};
            [6'd18:6'd21]: width_in  = {data_byte, width_ff[31:8]};
            [6'd22:6'd25]: height_in = {data_byte, height_ff[31:8]};
            [6'd26:6'd27]: planes_in = {data_byte, planes_ff[15:8]};
            [6'd28:6'd29]: bpp_in    = {data_byte, bpp_ff[15:8]};
            [6'd30:6'd33]: compr_in  = {data_byte, compr_ff[31:8]};
            [6'd34:6'd37]: isize_in  = {data_byte, isize_ff[31:8]};
            default: ;
         endcase
         pos_in = pos_cur + 6'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         sig_ff    <= '0;
         fsize_ff  <= '0;
         offset_ff <= '0;
         info_ff   <= '0;
         width_ff  <= '0;
         height_ff <= '0;
         planes_ff <= '0;
         bpp_ff    <= '0;
         compr_ff  <= '0;
         isize_ff  <= '0;
      end else begin
         pos_ff    <= pos_in;
         sig_ff    <= sig_in;
         fsize_ff  <= fsize_in;
         offset_ff <= offset_in;
         info_ff   <= info_in;
         width_ff  <= width_in;
         height_ff <= height_in;
         planes_ff <= planes_in;
         bpp_ff    <= bpp_in;
         compr_ff  <= compr_in;
         isize_ff  <= isize_in;
      end
   end

   always_comb begin
      status.sig_bad = (pos_cur == SIG_LAST_POS) && (sig_in != SIG_BM);
      status.at_end  = (pos_cur == HDR_LAST_POS);
      status.invalid = (bpp_ff != DEPTH_24) || (offset_ff != HDR_LEN) ||
                       (info_ff != INFO_LEN) || (fsize_ff != HDR_LEN + isize_ff) ||
                       (compr_ff != 32'd0) || (planes_ff != 16'd1) ||
                       (width_ff == 32'd0) || (height_ff == 32'd0);
      status.too_large = ({1'b0, width_ff} > COORD_LIMIT) ||
                         ({1'b0, height_ff} > COORD_LIMIT);
   end

   assign image_width  = width_ff;
   assign image_height = height_ff;

endmodule

@@ tb/sv/bmp24_stream_parser_tb.sv @@
`timescale 1ns / 1ps

module bmp24_stream_parser_tb;
   import bmp24_pkg::*;

   localparam int          COORD_BITS   = 16;
   localparam logic [63:0] COORD_LIMIT  = 64'd1 << COORD_BITS;
   localparam int          ITEM_TARGET  = 1000;
   localparam int          STALL_LIMIT  = 1000;

   typedef enum int {
      FLAW_NONE,
      FLAW_SIG_FIRST,
      FLAW_SIG_SECOND,
      FLAW_DEPTH,
      FLAW_OFFSET,
      FLAW_INFO,
      FLAW_FILE_SIZE,
      FLAW_COMPRESSION,
      FLAW_PLANES,
      FLAW_ZERO_WIDTH,
      FLAW_ZERO_HEIGHT,
      FLAW_WIDE,
      FLAW_TALL
   } flaw_kind_type;

   typedef struct {
      logic [7:0] data;
      logic       start;
      logic       drain;
   } byte_beat_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [15:0] row;
      logic [15:0] column;
      logic        last;
   } pixel_out_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;   // [7:0] data_byte
   logic        req_tuser;   // [0] file_start
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [55:0] rsp_tdata;   // [7:0] red, [15:8] green, [23:16] blue, [39:24] row, [55:40] column
   logic [1:0]  rsp_tuser;   // [1:0] status
   logic        rsp_tlast;   // last_pixel

   byte_beat_type  file_bytes[$];
   pixel_out_type  due_results[$];

   int          total_beats;
   int          beats_sent;
   int          files_built;
   int          pixels_seen;
   int          verdicts_seen;
   int          error_count;
   int          stalled_cycles;
   logic        req_took;
   wire         steady = (beats_sent >= 400) && (beats_sent < 600);

   // parser shadow state
   phase_type   phase_now;
   logic [5:0]  hdr_pos;
   logic [15:0] sig_word;
   logic [31:0] file_size;
   logic [31:0] data_offset;
   logic [31:0] info_size;
   logic [31:0] img_width;
   logic [31:0] img_height;
   logic [15:0] planes;
   logic [15:0] depth;
   logic [31:0] compression;
   logic [31:0] img_size;
   logic [31:0] row_at;
   logic [31:0] col_at;
   logic [1:0]  comp_sel;
   logic [7:0]  blue_held;
   logic [7:0]  green_held;
   logic [1:0]  pad_count;

   bmp24_stream_parser #(
      .COORD_BITS (COORD_BITS)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic clear_parser();
      phase_now   = PH_HEADER;
      hdr_pos     = '0;
      sig_word    = '0;
      file_size   = '0;
      data_offset = '0;
      info_size   = '0;
      img_width   = '0;
      img_height  = '0;
      planes      = '0;
      depth       = '0;
      compression = '0;
      img_size    = '0;
      row_at      = '0;
      col_at      = '0;
      comp_sel    = '0;
      blue_held   = '0;
      green_held  = '0;
      pad_count   = '0;
   endtask

   task automatic parse_byte(input logic [7:0] b, input logic start);
      int unsigned    p;
      logic           bad;
      logic           at_end;
      logic           fire;
      pixel_out_type  res;
      if (start) clear_parser();
      fire = 1'b0;
      res  = '0;
      case (phase_now)
         PH_HEADER: begin
            p = hdr_pos;
            // header fields arrive little-endian, so shift in from the top
            if (p < 2) sig_word = {b, sig_word[15:8]};
            else if (p < 6) file_size = {b, file_size[31:8]};
            else if (p < 10) ;
            else if (p < 14) data_offset = {b, data_offset[31:8]};
            else if (p < 18) info_size = {b, info_size[31:8]};
            else if (p < 22) img_width = {b, img_width[31:8]};
            else if (p < 26) img_height = {b, img_height[31:8]};
            else if (p < 28) planes = {b, planes[15:8]};
            else if (p < 30) depth = {b, depth[15:8]};
            else if (p < 34) compression = {b, compression[31:8]};
            else if (p < 38) img_size = {b, img_size[31:8]};
            hdr_pos = hdr_pos + 6'd1;
            if (hdr_pos == SIG_LAST_POS + 6'd1 && sig_word != SIG_BM) begin
               phase_now  = PH_IDLE;
               fire       = 1'b1;
               res.status = ST_BAD_SIG;
            end else if (hdr_pos == HDR_LAST_POS + 6'd1) begin
               bad = depth != DEPTH_24 || data_offset != HDR_LEN || info_size != INFO_LEN ||
                     file_size != HDR_LEN + img_size || compression != 32'd0 ||
                     planes != 16'd1 || img_width == 32'd0 || img_height == 32'd0;
               if (bad) begin
                  phase_now  = PH_IDLE;
                  fire       = 1'b1;
                  res.status = ST_BAD_HDR;
               end else if (img_width > COORD_LIMIT || img_height > COORD_LIMIT) begin
                  phase_now  = PH_IDLE;
                  fire       = 1'b1;
                  res.status = ST_TOO_LARGE;
               end else begin
                  phase_now = PH_PIXEL;
                  row_at    = '0;
                  col_at    = '0;
                  comp_sel  = '0;
               end
            end
         end
         PH_PIXEL: begin
            if (comp_sel == 2'd0) begin
               blue_held = b;
               comp_sel  = 2'd1;
            end else if (comp_sel == 2'd1) begin
               green_held = b;
               comp_sel   = 2'd2;
            end else begin
               comp_sel   = 2'd0;
               at_end     = (row_at == img_height - 32'd1) && (col_at == img_width - 32'd1);
               fire       = 1'b1;
               res.status = ST_PIXEL;
               res.red    = b;
               res.green  = green_held;
               res.blue   = blue_held;
               res.row    = row_at[15:0];
               res.column = col_at[15:0];
               res.last   = at_end;
               if (at_end) begin
                  phase_now = PH_IDLE;
               end else if (col_at + 32'd1 >= img_width) begin
                  col_at    = '0;
                  row_at    = row_at + 32'd1;
                  pad_count = img_width[1:0];
                  if (pad_count != 2'd0) phase_now = PH_PAD;
               end else begin
                  col_at = col_at + 32'd1;
               end
            end
         end
         PH_PAD: begin
            pad_count = pad_count - 2'd1;
            if (pad_count == 2'd0) phase_now = PH_PIXEL;
         end
         default: ;
      endcase
      if (fire) due_results.push_back(res);
   endtask

   task automatic push_beat(input logic [7:0] b, input logic start, input logic drain);
      byte_beat_type bt;
      bt.data  = b;
      bt.start = start;
      bt.drain = drain;
      file_bytes.push_back(bt);
   endtask

   // one file: header with at most one flaw, then, if unflawed, rows of bgr triples and padding
   task automatic add_file(input logic [31:0] w, input logic [31:0] h,
                           input flaw_kind_type flaw,
                           input logic marked, input int cut, input logic drain);
      logic [431:0] hdr;
      logic [31:0]  data_bytes;
      int           n;
      files_built++;
      for (int i = 0; i < 54; i++) hdr[8*i +: 8] = 8'($urandom);
      data_bytes = $urandom;
      case (flaw)
         FLAW_ZERO_WIDTH:  w = '0;
         FLAW_ZERO_HEIGHT: h = '0;
         FLAW_WIDE:        w = $urandom | 32'h0001_0001;
         FLAW_TALL:        h = $urandom | 32'h0001_0001;
         default: ;
      endcase
      hdr[0 +: 16]   = SIG_BM;
      hdr[16 +: 32]  = HDR_LEN + data_bytes;
      hdr[80 +: 32]  = HDR_LEN;
      hdr[112 +: 32] = INFO_LEN;
      hdr[144 +: 32] = w;
      hdr[176 +: 32] = h;
      hdr[208 +: 16] = 16'd1;
      hdr[224 +: 16] = DEPTH_24;
      hdr[240 +: 32] = '0;
      hdr[272 +: 32] = data_bytes;
      case (flaw)
         FLAW_SIG_FIRST:   hdr[0 +: 8]    = 8'h42 ^ (8'd1 << $urandom_range(7));
         FLAW_SIG_SECOND:  hdr[8 +: 8]    = 8'h4D ^ (8'd1 << $urandom_range(7));
         FLAW_DEPTH:       hdr[224 +: 16] = DEPTH_24 ^ (16'd1 << $urandom_range(15));
         FLAW_OFFSET:      hdr[80 +: 32]  = HDR_LEN ^ (32'd1 << $urandom_range(31));
         FLAW_INFO:        hdr[112 +: 32] = INFO_LEN ^ (32'd1 << $urandom_range(31));
         FLAW_FILE_SIZE:   hdr[16 +: 32]  = hdr[16 +: 32] ^ (32'd1 << $urandom_range(31));
         FLAW_COMPRESSION: hdr[240 +: 32] = 32'd1 << $urandom_range(31);
         FLAW_PLANES:      hdr[208 +: 16] = 16'd1 ^ (16'd1 << $urandom_range(15));
         default: ;
      endcase
      n = 0;
      for (int i = 0; i < 54; i++) begin
         if (n == cut) return;
         push_beat(hdr[8*i +: 8], marked && i == 0, drain && i == 0);
         n++;
      end
      if (flaw != FLAW_NONE) return;
      for (int unsigned r = 0; r < h; r++) begin
         for (int unsigned k = 0; k < 3 * w + w % 4; k++) begin
            if (n == cut) return;
            push_beat(8'($urandom), 1'b0, 1'b0);
            n++;
         end
      end
   endtask

   task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endtask

   task automatic check_result();
      pixel_out_type want;
      if (rsp_tuser == ST_PIXEL) pixels_seen++;
      else verdicts_seen++;
      if (due_results.size() == 0) begin
         $error("unexpected result beat: status %0d", rsp_tuser);
         error_count++;
      end else begin
         want = due_results.pop_front();
         check_field("status", want.status, rsp_tuser);
         check_field("red", want.red, rsp_tdata[7:0]);
         check_field("green", want.green, rsp_tdata[15:8]);
         check_field("blue", want.blue, rsp_tdata[23:16]);
         check_field("pixel_row", want.row, rsp_tdata[39:24]);
         check_field("pixel_column", want.column, rsp_tdata[55:40]);
         check_field("last_pixel", want.last, rsp_tlast);
      end
   endtask

   // driver: present the next byte once the previous beat has gone; a drain-marked byte waits until no result is due
   always @(negedge clock) begin
      byte_beat_type nxt;
      if (!reset) begin
         if (!req_tvalid || req_took) begin
            if (file_bytes.size() == 0 ||
                (file_bytes[0].drain && due_results.size() != 0) ||
                (!steady && $urandom_range(99) < 23)) begin
               req_tvalid <= 1'b0;
            end else begin
               nxt = file_bytes.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= nxt.data;
               req_tuser  <= nxt.start;
            end
         end
      end
   end

   always @(negedge clock) begin
      if (!reset) begin
         rsp_tready <= steady || ($urandom_range(99) >= 23);
      end
   end

   // monitor, shadow parser and watchdog
   always @(posedge clock) begin
      if (reset) begin
         req_took       = 1'b0;
         stalled_cycles = 0;
      end else begin
         req_took = req_tvalid && req_tready;
         if (req_took) begin
            parse_byte(req_tdata, req_tuser);
            beats_sent++;
         end
         if (rsp_tvalid && rsp_tready) check_result();
         if (req_took || (rsp_tvalid && rsp_tready)) stalled_cycles = 0;
         else stalled_cycles++;
         if (stalled_cycles == STALL_LIMIT) begin
            $display("timeout: no beat moved for %0d cycles", STALL_LIMIT);
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   initial begin
      int          pick;
      logic [31:0] w;
      logic [31:0] h;
      int          cut;
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      req_tuser     = 1'b0;
      rsp_tready    = 1'b0;
      req_took      = 1'b0;
      beats_sent    = 0;
      files_built   = 0;
      pixels_seen   = 0;
      verdicts_seen = 0;
      error_count   = 0;
      clear_parser();

      // first file arrives with no start mark, trailing pad and noise fall in idle
      add_file(1, 1, FLAW_NONE, 1'b0, -1, 1'b0);
      push_beat(8'h00, 1'b0, 1'b0);
      push_beat(8'hFF, 1'b0, 1'b0);
      add_file(3, 2, FLAW_NONE, 1'b1, -1, 1'b1);
      add_file(4, 1, FLAW_NONE, 1'b1, -1, 1'b0);
      add_file(2, 2, FLAW_NONE, 1'b1, -1, 1'b0);
      add_file(1, 1, FLAW_SIG_FIRST, 1'b1, 2, 1'b0);
      add_file(1, 1, FLAW_SIG_SECOND, 1'b1, 5, 1'b0);
      for (int f = FLAW_DEPTH; f <= FLAW_ZERO_HEIGHT; f++)
         add_file(2, 1, flaw_kind_type'(f), 1'b1, 54, 1'b0);
      // coordinate limit boundaries, negative height and cut-short files
      add_file(32'd65537, 1, FLAW_NONE, 1'b1, 54, 1'b0);
      add_file(1, 32'hFFFF_FFFF, FLAW_NONE, 1'b1, 54, 1'b0);
      add_file(32'd65536, 1, FLAW_NONE, 1'b1, 66, 1'b0);
      add_file(1, 32'd65536, FLAW_NONE, 1'b1, 63, 1'b0);
      add_file(2, 2, FLAW_NONE, 1'b1, 20, 1'b0);

      while (file_bytes.size() < ITEM_TARGET) begin
         pick = $urandom_range(99);
         if (pick < 65) begin
            w   = ($urandom_range(9) == 0) ? $urandom_range(6, 12) : $urandom_range(1, 5);
            h   = $urandom_range(1, 4);
            cut = ($urandom_range(9) == 0) ? 54 + $urandom_range(1, 3 * w * h) : -1;
            add_file(w, h, FLAW_NONE, 1'b1, cut, files_built % 7 == 3);
         end else if (pick < 75) begin
            add_file(2, 2, flaw_kind_type'($urandom_range(FLAW_DEPTH, FLAW_ZERO_HEIGHT)),
                     1'b1, 54, files_built % 7 == 3);
         end else if (pick < 80) begin
            add_file(3, 1, $urandom_range(1) ? FLAW_WIDE : FLAW_TALL, 1'b1, 54, 1'b0);
         end else if (pick < 88) begin
            add_file(1, 1, $urandom_range(1) ? FLAW_SIG_FIRST : FLAW_SIG_SECOND,
                     1'b1, $urandom_range(2, 8), 1'b0);
         end else begin
            repeat ($urandom_range(1, 6))
               push_beat(8'($urandom), $urandom_range(3) == 0, 1'b0);
         end
         if ($urandom_range(9) < 3)
            repeat ($urandom_range(1, 4)) push_beat(8'($urandom), 1'b0, 1'b0);
      end
      total_beats = file_bytes.size();

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      wait (beats_sent == total_beats);
      wait (due_results.size() == 0);
      repeat (10) @(posedge clock);

      $display("covered %0d byte beats over %0d files, with and without start marks",
               beats_sent, files_built);
      $display("checked %0d pixels and %0d error verdicts", pixels_seen, verdicts_seen);
      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

@@ bmp24_stream_parser.f @@
hw/rtl/bmp24_pkg.sv
hw/rtl/bmp24_hdr.sv
hw/rtl/bmp24_stream_parser.sv
tb/sv/bmp24_stream_parser_tb.sv
